// ----- rtl/whole_word_occurrence_counter_top_macros.svh -----
// Assertion macros shared by the whole-word occurrence counter RTL.
`ifndef WHOLE_WORD_OCCURRENCE_COUNTER_TOP_MACROS_SVH
`define WHOLE_WORD_OCCURRENCE_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WWOC_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WWOC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wwoc_pkg.sv -----
// Shared types, constants and helper functions of the whole-word occurrence counter.
`default_nettype none

package wwoc_pkg;

    localparam int BYTE_W             = 8;
    localparam int WORD_LEN_W         = 5;
    localparam int WORD_REG_BYTES     = 16;
    localparam int WORD_BYTES_W       = WORD_REG_BYTES * BYTE_W;
    localparam int CFG_DATA_W         = 64;
    localparam int CFG_IDX_W          = 2;
    localparam int COUNT_W            = 32;
    localparam int MAX_WORD_BYTES_DEF = 16;
    localparam int SEGMENT_LIMIT_DEF  = 1023;

    localparam logic [BYTE_W-1:0]     NEWLINE_BYTE = 8'h0A;
    localparam logic [WORD_LEN_W-1:0] WORD_LEN_RST = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_LENGTH = 2'd0,
        REG_WORD_LOW    = 2'd1,
        REG_WORD_HIGH   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_LEN_W-1:0]   word_length;
        logic [WORD_BYTES_W-1:0] word_bytes;
    } cfg_t;

    function automatic logic is_alnum(input logic [BYTE_W-1:0] b);
        logic digit;
        logic upper;
        logic lower;
        digit = (b >= 8'h30) && (b <= 8'h39);
        upper = (b >= 8'h41) && (b <= 8'h5A);
        lower = (b >= 8'h61) && (b <= 8'h7A);
        return digit || upper || lower;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wwoc_in_if.sv -----
// Text byte channel: valid/ready handshake with one stream byte per request.
`default_nettype none

interface wwoc_in_if import wwoc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// ----- rtl/wwoc_out_if.sv -----
// Result channel: valid/ready handshake carrying the stream's occurrence total.
`default_nettype none

interface wwoc_out_if import wwoc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] total_count;

    modport source (output valid, output total_count, input ready);
    modport sink   (input valid, input total_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/whole_word_occurrence_counter_top.sv -----
// Top level of the whole-word occurrence counter: channel staging, counting and result register.
//
//   channel  | dir | payload                          | request moves
//   ---------+-----+----------------------------------+----------------------------
//   stream   | in  | data_byte[7:0], end_of_stream    | valid && ready
//   result   | out | total_count[31:0]                | valid && ready
//   cfg      | in  | cfg_index[1:0], cfg_data[63:0]   | cfg_write (no wait)
//
// Each byte is scanned while it sits in the input register; one byte per cycle is sustained
// unless an end-of-stream byte waits there on a held result; scanning it loads the total.
// The per-byte state update (window, segment position, pending match) is combinational.
// Reset is asynchronous and active low and leaves the word length at one.
// A stalled result holds back only an end-of-stream request; other bytes keep flowing.
`default_nettype none

`include "whole_word_occurrence_counter_top_macros.svh"

module whole_word_occurrence_counter_top import wwoc_pkg::*; #(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF,
    parameter int SEGMENT_LIMIT  = SEGMENT_LIMIT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    wwoc_in_if.sink                    stream,
    wwoc_out_if.source                 result,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_eos_reg;
    logic              s1_fire;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W:0]   count_sum;
    logic [1:0]         incr;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COUNT_W-1:0] out_count_reg;

    wwoc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wwoc_scan #(
        .MAX_WORD_BYTES (MAX_WORD_BYTES),
        .SEGMENT_LIMIT  (SEGMENT_LIMIT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (s1_fire),
        .step_byte  (s1_byte_reg),
        .step_eos   (s1_eos_reg),
        .cfg        (cfg),
        .incr       (incr)
    );

    // An end-of-stream byte needs a free result slot before it can be scanned.
    assign s1_fire      = s1_valid_reg && (!s1_eos_reg || !out_valid_reg || result.ready);
    assign stream.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            s1_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            s1_byte_reg <= stream.data_byte;
            s1_eos_reg  <= stream.end_of_stream;
        end
    end

    // Up to two occurrences can close on one byte; the total saturates at all ones.
    assign count_sum  = {1'b0, count_reg} + (COUNT_W + 1)'(incr);
    assign count_next = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (s1_fire)
        begin
            count_reg <= s1_eos_reg ? '0 : count_next;
        end
    end

    assign out_valid_next = (out_valid_reg && !result.ready) || (s1_fire && s1_eos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_eos_reg)
        begin
            out_count_reg <= count_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.total_count = out_count_reg;

    `WWOC_ASSERT_NEXT(a_eos_loads_result, clk, rst_n, s1_fire && s1_eos_reg,
        out_valid_reg && (count_reg == '0), "end of stream did not load the result")
    `WWOC_ASSERT_NEXT(a_stall_holds_byte, clk, rst_n, s1_valid_reg && !s1_fire,
        s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_eos_reg),
        "staged byte lost during a result stall")
    `WWOC_ASSERT_IMPL(a_stall_only_on_eos, clk, rst_n, s1_valid_reg && !s1_fire,
        s1_eos_reg && out_valid_reg && !result.ready, "input stalled without a blocked result")

endmodule

`default_nettype wire

// ----- rtl/wwoc_cfg.sv -----
// Configuration register file holding the target word and its length.
`default_nettype none

module wwoc_cfg import wwoc_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    logic [WORD_LEN_W-1:0] word_length_reg;
    logic [CFG_DATA_W-1:0] word_low_reg;
    logic [CFG_DATA_W-1:0] word_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= WORD_LEN_RST;
            word_low_reg    <= '0;
            word_high_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WORD_LENGTH: word_length_reg <= cfg_data[WORD_LEN_W-1:0];
                REG_WORD_LOW:    word_low_reg    <= cfg_data;
                REG_WORD_HIGH:   word_high_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = '{word_length: word_length_reg, word_bytes: {word_high_reg, word_low_reg}};

endmodule

`default_nettype wire

// ----- rtl/wwoc_scan.sv -----
// Byte window, segment tracking, whole-word matching: one byte per step_valid cycle.
`default_nettype none

`include "whole_word_occurrence_counter_top_macros.svh"

module wwoc_scan import wwoc_pkg::*; #(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF,
    parameter int SEGMENT_LIMIT  = SEGMENT_LIMIT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_valid,
    input  wire logic [BYTE_W-1:0] step_byte,
    input  wire logic              step_eos,
    input  wire cfg_t              cfg,
    output logic [1:0]             incr
);

    localparam int IDX_W  = $clog2(MAX_WORD_BYTES + 1);
    localparam int POS_W  = $clog2(SEGMENT_LIMIT + 1);
    localparam int W_A    = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam int W_B    = (W_A > WORD_LEN_W) ? W_A : WORD_LEN_W;
    localparam int CMP_W  = W_B + 1;

    localparam logic [CMP_W-1:0] MAX_C   = CMP_W'(MAX_WORD_BYTES);
    localparam logic [CMP_W-1:0] LIMIT_C = CMP_W'(SEGMENT_LIMIT);
    localparam logic [IDX_W-1:0] MAX_I   = IDX_W'(MAX_WORD_BYTES);

    logic [BYTE_W-1:0] win_reg [MAX_WORD_BYTES+1];
    logic [BYTE_W-1:0] win_new [MAX_WORD_BYTES+1];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [IDX_W-1:0]  bsme_reg;
    logic [IDX_W-1:0]  bsme_next;
    logic              pending_reg;
    logic              pending_next;

    logic [CMP_W-1:0]          wl_ext;
    logic [CMP_W-1:0]          len_c;
    logic [CMP_W-1:0]          pos_p1;
    logic [IDX_W-1:0]          bsme_inc;
    logic [MAX_WORD_BYTES-1:0] byte_eq;
    logic                      seg_end;
    logic                      hit;
    logic                      left_ok;
    logic                      pend_add;
    logic                      match_add;

    // Window as it stands after the current byte is shifted in, newest at index 0.
    always_comb
    begin
        win_new[0] = step_byte;
        for (int k = 1; k <= MAX_WORD_BYTES; k++)
        begin
            win_new[k] = win_reg[k-1];
        end
    end

    assign wl_ext   = CMP_W'(cfg.word_length);
    assign len_c    = (wl_ext > MAX_C) ? MAX_C : wl_ext;
    assign pos_p1   = CMP_W'(pos_reg) + CMP_W'(1);
    assign bsme_inc = (bsme_reg < MAX_I) ? (bsme_reg + IDX_W'(1)) : bsme_reg;
    assign seg_end  = (step_byte == NEWLINE_BYTE) || (pos_p1 >= LIMIT_C) || step_eos;

    // Word byte k lines up with the byte that arrived len-1-k bytes ago.
    for (genvar k = 0; k < MAX_WORD_BYTES; k++)
    begin : g_cmp
        logic [CMP_W-1:0]  sel;
        logic [BYTE_W-1:0] wbyte;

        assign sel = len_c - CMP_W'(k + 1);
        if (k < WORD_REG_BYTES)
        begin : g_cfg
            assign wbyte = cfg.word_bytes[k*BYTE_W +: BYTE_W];
        end
        else
        begin : g_zero
            assign wbyte = '0;
        end
        assign byte_eq[k] = (CMP_W'(k) >= len_c) || (wbyte == win_new[sel[IDX_W-1:0]]);
    end

    assign hit = (len_c != '0) && (pos_p1 >= len_c) && (CMP_W'(bsme_inc) >= len_c) && (&byte_eq);
    assign left_ok   = (pos_p1 == len_c) || !is_alnum(win_new[len_c[IDX_W-1:0]]);
    assign pend_add  = pending_reg && !is_alnum(step_byte);
    assign match_add = hit && left_ok && seg_end;
    assign incr      = {1'b0, pend_add} + {1'b0, match_add};

    always_comb
    begin
        if (seg_end)
        begin
            pos_next     = '0;
            bsme_next    = MAX_I;
            pending_next = 1'b0;
        end
        else
        begin
            pos_next     = pos_p1[POS_W-1:0];
            bsme_next    = hit ? '0 : bsme_inc;
            pending_next = hit && left_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            bsme_reg    <= MAX_I;
            pending_reg <= 1'b0;
            for (int k = 0; k <= MAX_WORD_BYTES; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (step_valid)
        begin
            pos_reg     <= pos_next;
            bsme_reg    <= bsme_next;
            pending_reg <= pending_next;
            for (int k = 0; k <= MAX_WORD_BYTES; k++)
            begin
                win_reg[k] <= step_eos ? '0 : win_new[k];
            end
        end
    end

    `WWOC_ASSERT_NEXT(a_eos_clears, clk, rst_n, step_valid && step_eos,
        (pos_reg == '0) && !pending_reg && (bsme_reg == MAX_I) && (win_reg[0] == '0),
        "stream state not cleared after end of stream")
    `WWOC_ASSERT_IMPL(a_pending_after_match, clk, rst_n, pending_reg,
        (bsme_reg == '0) && (pos_reg != '0), "pending match without a fresh match inside a segment")
    `WWOC_ASSERT_IMPL(a_gap_bounded, clk, rst_n, 1'b1, bsme_reg <= MAX_I,
        "match gap counter beyond its saturation value")

endmodule

`default_nettype wire

// ----- test/whole_word_occurrence_counter_top_tb.sv -----
// Self-checking bench for the whole-word occurrence counter: random text streams and a total scoreboard.
module whole_word_occurrence_counter_top_tb;
    import wwoc_pkg::*;

    localparam int WIN          = MAX_WORD_BYTES_DEF;
    localparam int SEG_LIMIT    = SEGMENT_LIMIT_DEF;
    localparam int PHASE_BYTES  = 60;
    localparam int LONG_STREAM  = 1100;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_AFTER   = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 6;
    localparam int N_SEPS       = 12;
    // Punctuation, including the neighbors of each alphanumeric range.
    localparam logic [BYTE_W-1:0] SEP_CHARS [N_SEPS] = '{
        8'h20, 8'h2C, 8'h2E, 8'h2D, 8'h21, 8'h28, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B
    };

    typedef enum int {W_ALNUM, W_REPEAT, W_ANY, W_ONES} word_style_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } text_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WORD_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wwoc_in_if  stream_ch();
    wwoc_out_if result_ch();

    whole_word_occurrence_counter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Counting state of the predictor.
    logic [WORD_LEN_W-1:0]   model_len = WORD_LEN_RST;
    logic [WORD_BYTES_W-1:0] model_word = '0;
    logic [BYTE_W-1:0]       history [0:WIN];
    int unsigned             seg_pos;
    int unsigned             since_hit;
    bit                      hit_pending;
    logic [COUNT_W-1:0]      tally;

    logic [COUNT_W-1:0] totals_due [$];
    text_req_t          pending_bytes [$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 bytes_taken = 0;

    int gap_left = 0;
    int drv_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_left = 0;
    int rcv_calm = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_word_char(input logic [BYTE_W-1:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return BYTE_W'(8'h30 + r);
        if (r < 36)
            return BYTE_W'(8'h41 + r - 10);
        return BYTE_W'(8'h61 + r - 36);
    endfunction

    // Bytes at or above n are filled with junk that the block must ignore.
    function automatic logic [WORD_BYTES_W-1:0] make_word(input int n, input word_style_t style);
        logic [WORD_BYTES_W-1:0] w;
        logic [BYTE_W-1:0]       c;
        int                      k;
        c = pick_alnum();
        for (k = 0; k < WORD_REG_BYTES; k++)
        begin
            if (k >= n)
                w[8*k +: 8] = BYTE_W'($urandom);
            else
            begin
                case (style)
                    W_ALNUM:  w[8*k +: 8] = pick_alnum();
                    W_REPEAT: w[8*k +: 8] = c;
                    W_ANY:    w[8*k +: 8] = ($urandom_range(0, 4) == 0) ? '0 : BYTE_W'($urandom);
                    default:  w[8*k +: 8] = 8'hFF;
                endcase
            end
        end
        return w;
    endfunction

    task automatic clear_stream_state();
        int k;
        for (k = 0; k <= WIN; k++)
            history[k] = '0;
        seg_pos = 0;
        since_hit = WIN;
        hit_pending = 1'b0;
        tally = '0;
    endtask

    // Advances the predictor by one stream byte; an end-of-stream byte yields a total.
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic eos);
        int unsigned len;
        int          k;
        bit          seg_end;
        bit          hit;
        len = (model_len > WIN) ? WIN : model_len;
        for (k = WIN; k > 0; k--)
            history[k] = history[k-1];
        history[0] = b;
        if (hit_pending)
        begin
            if (!is_word_char(b) && tally != '1)
                tally++;
            hit_pending = 1'b0;
        end
        if (since_hit < WIN)
            since_hit++;
        seg_end = (b == NEWLINE_BYTE) || (seg_pos + 1 >= SEG_LIMIT) || eos;
        if (len >= 1 && seg_pos + 1 >= len && since_hit >= len)
        begin
            hit = 1'b1;
            for (k = 0; k < len; k++)
                if (model_word[8*k +: 8] != history[len-1-k])
                    hit = 1'b0;
            if (hit)
            begin
                since_hit = 0;
                if (seg_pos + 1 == len || !is_word_char(history[len]))
                begin
                    // At a segment end the right side needs no further byte.
                    if (seg_end)
                    begin
                        if (tally != '1)
                            tally++;
                    end
                    else
                        hit_pending = 1'b1;
                end
            end
        end
        if (seg_end)
        begin
            seg_pos = 0;
            since_hit = WIN;
            hit_pending = 1'b0;
        end
        else
            seg_pos++;
        if (eos)
        begin
            totals_due.push_back(tally);
            clear_stream_state();
        end
    endtask

    task automatic flag_error(input string what);
        if (errors < 40)
            $display("MISMATCH at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_WORD_LENGTH: model_len = value[WORD_LEN_W-1:0];
            REG_WORD_LOW:    model_word[63:0] = value;
            REG_WORD_HIGH:   model_word[127:64] = value;
            default:         ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // The length register is written with random bits above its field.
    task automatic configure(input int unsigned len, input logic [WORD_BYTES_W-1:0] word);
        logic [CFG_DATA_W-1:0] len_value;
        len_value = {$urandom, $urandom};
        len_value[WORD_LEN_W-1:0] = len[WORD_LEN_W-1:0];
        write_reg(REG_WORD_LENGTH, len_value);
        write_reg(REG_WORD_LOW, word[63:0]);
        write_reg(REG_WORD_HIGH, word[127:64]);
        @(negedge clk);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back('{data_byte: b, end_of_stream: 1'b0});
    endtask

    task automatic end_stream();
        text_req_t last;
        last = pending_bytes.pop_back();
        last.end_of_stream = 1'b1;
        pending_bytes.push_back(last);
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
        end_stream();
    endtask

    // One stream of random tokens, about two in five of them copies or near copies of the word.
    task automatic add_stream(input int n_tokens);
        int unsigned eff;
        int          start;
        int          cut;
        int          t;
        int          k;
        eff = (model_len > WIN) ? WIN : model_len;
        start = pending_bytes.size();
        for (t = 0; t < n_tokens; t++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:
                begin
                    for (k = 0; k < eff; k++)
                        push_byte(model_word[8*k +: 8]);
                end
                6, 7:
                begin
                    cut = $urandom_range(0, eff);
                    for (k = 0; k < cut; k++)
                        push_byte(model_word[8*k +: 8]);
                    push_byte(pick_alnum());
                end
                8, 9, 10:
                begin
                    repeat ($urandom_range(1, 5))
                        push_byte(pick_alnum());
                end
                11, 12, 13, 14, 15:
                begin
                    repeat ($urandom_range(1, 2))
                        push_byte(SEP_CHARS[$urandom_range(0, N_SEPS-1)]);
                end
                16:      push_byte(NEWLINE_BYTE);
                17, 18:  push_byte(BYTE_W'($urandom));
                default: push_byte('0);
            endcase
        end
        if (pending_bytes.size() == start || $urandom_range(0, 1) == 1)
            push_byte($urandom_range(0, 1) ? SEP_CHARS[$urandom_range(0, N_SEPS-1)]
                                           : BYTE_W'($urandom));
        end_stream();
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || stream_ch.valid || totals_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sender: each accepted request goes through the predictor before the next is offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_ch.valid <= 1'b0;
            stream_ch.data_byte <= '0;
            stream_ch.end_of_stream <= 1'b0;
        end
        else
        begin
            if (stream_ch.valid && stream_ch.ready)
            begin
                scan_byte(stream_ch.data_byte, stream_ch.end_of_stream);
                bytes_taken <= bytes_taken + 1;
            end
            if (!stream_ch.valid || stream_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    stream_ch.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_bytes.size() != 0)
                begin
                    stream_ch.valid <= 1'b1;
                    stream_ch.data_byte <= pending_bytes[0].data_byte;
                    stream_ch.end_of_stream <= pending_bytes[0].end_of_stream;
                    void'(pending_bytes.pop_front());
                    gap_left <= (drv_calm > 0) ? 0 : pick_gap();
                end
                else
                    stream_ch.valid <= 1'b0;
            end
            if (drv_calm > 0)
                drv_calm <= drv_calm - 1;
            else if ($urandom_range(0, 49) == 0)
                drv_calm <= $urandom_range(20, 80);
        end
    end

    // Receiver: checks each total, stalls at random and once holds off long enough
    // for the block to back up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (totals_due.size() == 0)
                    flag_error($sformatf("unexpected total_count %0d", result_ch.total_count));
                else
                begin
                    if (result_ch.total_count !== totals_due[0])
                        flag_error($sformatf("total_count got %0d expected %0d",
                                             result_ch.total_count, totals_due[0]));
                    void'(totals_due.pop_front());
                end
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && bytes_taken >= HOLD_AFTER)
            begin
                result_ch.ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (rcv_calm > 0)
            begin
                result_ch.ready <= 1'b1;
                rcv_calm <= rcv_calm - 1;
            end
            else
            begin
                case ($urandom_range(0, 29))
                    0:
                    begin
                        result_ch.ready <= 1'b1;
                        rcv_calm <= $urandom_range(20, 80);
                    end
                    1, 2, 3, 4, 5:
                    begin
                        result_ch.ready <= 1'b0;
                        stall_left <= pick_gap();
                    end
                    default: result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin
        int          phase;
        int unsigned len;
        int          target;
        int          k;
        word_style_t style;

        clear_stream_state();
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // A hit that ends on the end-of-stream byte, then a hit that swallows the next
        // one and a hit whose left neighbor is alphanumeric.
        configure(2, {{14{8'h55}}, 8'h62, 8'h61});
        queue_text("ab");
        queue_text("abab,ab");
        drain();

        // A zero word length never matches.
        configure(0, {{15{8'h00}}, 8'h61});
        queue_text("a");
        drain();

        // Zero bytes compare like any other value.
        configure(3, '0);
        repeat (3) push_byte('0);
        end_stream();
        drain();

        // A length above the window is cut down to the full sixteen bytes.
        configure(31, make_word(WORD_REG_BYTES, W_ALNUM));
        for (k = 0; k < WORD_REG_BYTES; k++)
            push_byte(model_word[8*k +: 8]);
        end_stream();
        drain();

        for (phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:
                begin
                    len = 1;
                    style = W_ALNUM;
                end
                1:
                begin
                    len = $urandom_range(2, 4);
                    style = W_ALNUM;
                end
                2:
                begin
                    len = $urandom_range(2, 3);
                    style = W_REPEAT;
                end
                3:
                begin
                    len = WIN;
                    style = W_ALNUM;
                end
                4:
                begin
                    len = 31;
                    style = W_ALNUM;
                end
                5:
                begin
                    len = 0;
                    style = W_ALNUM;
                end
                6:
                begin
                    len = WIN;
                    style = W_ONES;
                end
                7:
                begin
                    len = $urandom_range(1, 6);
                    style = W_ANY;
                end
                8:
                begin
                    len = 3;
                    style = W_ALNUM;
                end
                default:
                begin
                    len = $urandom_range(17, 30);
                    style = W_REPEAT;
                end
            endcase
            configure(len, make_word((len > WIN) ? WIN : len, style));
            if (phase == 8)
            begin
                // One stream with no newline, so the segment length limit cuts it.
                while (pending_bytes.size() < LONG_STREAM)
                begin
                    for (k = 0; k < 3; k++)
                        push_byte(model_word[8*k +: 8]);
                    repeat ($urandom_range(1, 2))
                        push_byte(SEP_CHARS[$urandom_range(0, N_SEPS-1)]);
                end
                end_stream();
            end
            target = pending_bytes.size() + PHASE_BYTES;
            while (pending_bytes.size() < target)
                add_stream(($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                      : $urandom_range(1, 8));
            drain();
        end

        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
